FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, off while rst is high.
`define IHB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define IHB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ihb_pkg.sv
`default_nettype none

package ihb_pkg;

  localparam int DEF_ROWS    = 64;
  localparam int DEF_COLS    = 64;
  localparam int COORD_W     = 6;
  localparam int FRAC_W      = 32;
  localparam int NUM_PROBS   = 5;
  localparam int NUM_NB      = 4;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [FRAC_W-1:0] PROB_RESET = 32'h8000_0000;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROB_M4    = 3'd0,
    REG_PROB_M2    = 3'd1,
    REG_PROB_ZERO  = 3'd2,
    REG_PROB_P2    = 3'd3,
    REG_PROB_P4    = 3'd4,
    REG_SWEEP_MODE = 3'd5
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_NEAREST    = 2'd0,
    MODE_DIAG_SAME  = 2'd1,
    MODE_DIAG_CROSS = 2'd2
  } sweep_mode_t;

  typedef logic [NUM_PROBS-1:0][FRAC_W-1:0] prob_tab_t;

  // Per-item control handed from the site sequencer to the update pipeline.
  typedef struct packed {
    logic               upd;
    logic               wr_en;
    logic               spin;
    logic               done;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } item_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/ihb_spin_ram.sv
`default_nettype none

module ihb_spin_ram #(
  parameter int AW = $clog2(ihb_pkg::DEF_ROWS) + $clog2(ihb_pkg::DEF_COLS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic          wd,
  input  logic          re,
  input  logic [AW-1:0] ra0,
  input  logic [AW-1:0] ra1,
  output logic          rd0,
  output logic          rd1
);

  localparam int DEPTH = 1 << AW;

  logic mem [DEPTH];

  // Read returns the value before a same-edge write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd0 <= mem[ra0];
      rd1 <= mem[ra1];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ihb_queue.sv
`default_nettype none

module ihb_queue #(
  parameter int W     = ihb_pkg::FRAC_W,
  parameter int DEPTH = ihb_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         valid,
  output logic         full
);

  localparam int PW = $clog2(DEPTH);

  logic [W-1:0] entry [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign rdata = entry[rd_ptr];
  assign valid = (count != '0);
  assign full  = (count == (PW+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (!push && pop) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ihb_front.sv
`default_nettype none

module ihb_front #(
  parameter int ROWS = ihb_pkg::DEF_ROWS,
  parameter int COLS = ihb_pkg::DEF_COLS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic                                   kind,
  input  logic [ihb_pkg::COORD_W-1:0]            row,
  input  logic [ihb_pkg::COORD_W-1:0]            col,
  input  logic                                   spin_value,
  input  logic [ihb_pkg::FRAC_W-1:0]             random_draw,
  input  logic [ihb_pkg::MODE_W-1:0]             mode,
  input  logic                                   q_full,
  input  logic                                   clear_busy,
  output logic                                   push,
  output ihb_pkg::item_ctrl_t                    e_ctrl,
  output logic [$clog2(ROWS)+$clog2(COLS)-1:0]   e_addr,
  output logic [ihb_pkg::NUM_NB-1:0][$clog2(ROWS)+$clog2(COLS)-1:0] e_nb,
  output logic [ihb_pkg::FRAC_W-1:0]             e_draw
);

  localparam int RW  = $clog2(ROWS);
  localparam int CW  = $clog2(COLS);
  localparam int RXW = ((RW > ihb_pkg::COORD_W) ? RW : ihb_pkg::COORD_W) + 1;
  localparam int CXW = ((CW > ihb_pkg::COORD_W) ? CW : ihb_pkg::COORD_W) + 1;
  localparam logic [RW+1:0] ROWS_X = (RW+2)'(ROWS);
  localparam logic [CW+1:0] COLS_X = (CW+2)'(COLS);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

  typedef struct packed {
    logic          found;
    logic [RW-1:0] r;
    logic [CW-1:0] c;
  } pos_t;

  // First site of phase ph at or after (r, c) in raster order.
  function automatic pos_t next_site(input logic [RW-1:0] r, input logic [CW:0] c,
                                     input logic m0, input logic m2, input logic ph);
    logic          row_ok;
    logic          colpar;
    logic          rowpar;
    logic [CW+1:0] cand;
    logic [1:0]    rstep;
    logic [RW+1:0] rr;
    pos_t          res;
    row_ok = m0 | (r[0] == ph);
    colpar = m0 ? (ph ^ r[0]) : (ph ^ m2);
    cand   = {1'b0, c} + (CW+2)'(c[0] ^ colpar);
    rstep  = (m0 || (r[0] != ph)) ? 2'd1 : 2'd2;
    rr     = {2'b00, r} + (RW+2)'(rstep);
    rowpar = m0 ? (ph ^ rr[0]) : (ph ^ m2);
    res    = '0;
    if (row_ok && (cand < COLS_X)) begin
      res.found = 1'b1;
      res.r     = r;
      res.c     = cand[CW-1:0];
    end else if (rr < ROWS_X) begin
      res.found = 1'b1;
      res.r     = rr[RW-1:0];
      res.c     = CW'(rowpar);
    end
    return res;
  endfunction

  logic          phase;
  logic [RW-1:0] row_pos;
  logic [CW-1:0] col_pos;

  logic          m0;
  logic          m2;
  pos_t          first;
  pos_t          restart;
  pos_t          site;
  pos_t          succ;
  logic          ph_used;
  logic          done_u;
  logic [RW-1:0] rp;
  logic [RW-1:0] rn;
  logic [CW-1:0] cp;
  logic [CW-1:0] cn;
  logic          w_in;
  logic          is_upd;

  assign item_stall = clear_busy || q_full;
  assign push       = item_valid && !item_stall;
  assign is_upd     = (kind == ihb_pkg::KIND_UPDATE);

  // Mode three falls back to the nearest-neighbour checkerboard.
  assign m0 = !((mode == ihb_pkg::MODE_DIAG_SAME) || (mode == ihb_pkg::MODE_DIAG_CROSS));
  assign m2 = (mode == ihb_pkg::MODE_DIAG_CROSS);

  always_comb begin
    first   = next_site(row_pos, {1'b0, col_pos}, m0, m2, phase);
    restart = next_site('0, '0, m0, m2, !phase);
    // Nothing left in this phase under the current mode: toggle and restart.
    if (first.found) begin
      site    = first;
      ph_used = phase;
    end else begin
      site    = restart;
      ph_used = !phase;
    end
    succ   = next_site(site.r, {1'b0, site.c} + (CW+1)'(1), m0, m2, ph_used);
    done_u = !succ.found && ph_used;
    rp = (site.r == '0) ? ROW_LAST : site.r - RW'(1);
    rn = (site.r == ROW_LAST) ? '0 : site.r + RW'(1);
    cp = (site.c == '0) ? COL_LAST : site.c - CW'(1);
    cn = (site.c == COL_LAST) ? '0 : site.c + CW'(1);
  end

  assign w_in = (RXW'(row) < RXW'(ROWS)) && (CXW'(col) < CXW'(COLS));

  always_comb begin
    if (m0) begin
      e_nb[0] = {rn, site.c};
      e_nb[1] = {rp, site.c};
      e_nb[2] = {site.r, cn};
      e_nb[3] = {site.r, cp};
    end else begin
      e_nb[0] = {rp, cp};
      e_nb[1] = {rn, cp};
      e_nb[2] = {rp, cn};
      e_nb[3] = {rn, cn};
    end
    e_draw = random_draw;
    if (is_upd) begin
      e_addr       = {site.r, site.c};
      e_ctrl.upd   = 1'b1;
      e_ctrl.wr_en = 1'b1;
      e_ctrl.spin  = 1'b0;
      e_ctrl.done  = done_u;
      e_ctrl.row   = ihb_pkg::COORD_W'(site.r);
      e_ctrl.col   = ihb_pkg::COORD_W'(site.c);
    end else begin
      e_addr       = {RW'(row), CW'(col)};
      e_ctrl.upd   = 1'b0;
      e_ctrl.wr_en = w_in;
      e_ctrl.spin  = spin_value & w_in;
      e_ctrl.done  = 1'b0;
      e_ctrl.row   = row;
      e_ctrl.col   = col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= 1'b0;
      row_pos <= '0;
      col_pos <= '0;
    end else if (push && is_upd) begin
      if (succ.found) begin
        phase   <= ph_used;
        row_pos <= succ.r;
        col_pos <= succ.c;
      end else begin
        phase   <= !ph_used;
        row_pos <= '0;
        col_pos <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ihb_back.sv
`default_nettype none

module ihb_back #(
  parameter int ROWS = ihb_pkg::DEF_ROWS,
  parameter int COLS = ihb_pkg::DEF_COLS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ihb_pkg::prob_tab_t                     prob,
  input  logic                                   q_valid,
  input  ihb_pkg::item_ctrl_t                    q_ctrl,
  input  logic [$clog2(ROWS)+$clog2(COLS)-1:0]   q_addr,
  input  logic [ihb_pkg::NUM_NB-1:0][$clog2(ROWS)+$clog2(COLS)-1:0] q_nb,
  input  logic [ihb_pkg::FRAC_W-1:0]             q_draw,
  output logic                                   q_pop,
  output logic                                   clear_busy,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic [ihb_pkg::COORD_W-1:0]            site_row,
  output logic [ihb_pkg::COORD_W-1:0]            site_col,
  output logic                                   new_spin,
  output logic                                   sweep_done
);

  localparam int AW = $clog2(ROWS) + $clog2(COLS);

  logic          clearing;
  logic [AW-1:0] clr_cnt;

  logic                              s2_valid;
  ihb_pkg::item_ctrl_t               s2_ctrl;
  logic [AW-1:0]                     s2_addr;
  logic [ihb_pkg::NUM_NB-1:0][AW-1:0] s2_nb;
  logic [ihb_pkg::FRAC_W-1:0]        s2_draw;
  logic                              s2_adv;
  logic                              s2_ready;
  logic                              pop;

  logic [ihb_pkg::NUM_NB-1:0] rd;
  logic [ihb_pkg::NUM_NB-1:0] nb_bit;
  logic [2:0]                 ups;
  logic                       upd_spin;
  logic                       spin_new;

  logic          pw_valid;
  logic [AW-1:0] pw_addr;
  logic          pw_data;

  logic          ram_we;
  logic [AW-1:0] ram_wa;
  logic          ram_wd;

  assign clear_busy = clearing;
  assign s2_adv     = s2_valid && (!result_valid || !result_stall);
  assign s2_ready   = !s2_valid || s2_adv;
  assign pop        = q_valid && s2_ready && !clearing;
  assign q_pop      = pop;

  assign ram_we = clearing || (s2_adv && s2_ctrl.wr_en);
  assign ram_wa = clearing ? clr_cnt : s2_addr;
  assign ram_wd = clearing | spin_new;

  // Two copies with two read ports each give the four neighbour reads.
  ihb_spin_ram #(.AW(AW)) u_ram_a (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (pop),
    .ra0 (q_nb[0]),
    .ra1 (q_nb[1]),
    .rd0 (rd[0]),
    .rd1 (rd[1])
  );

  ihb_spin_ram #(.AW(AW)) u_ram_b (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (pop),
    .ra0 (q_nb[2]),
    .ra1 (q_nb[3]),
    .rd0 (rd[2]),
    .rd1 (rd[3])
  );

  // Fill every spin with +1 after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + AW'(1);
      if (&clr_cnt) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    // The write landing on the same edge as this item's read is not in the
    // read data yet; take it from the last-write register.
    for (int k = 0; k < ihb_pkg::NUM_NB; k++) begin
      nb_bit[k] = (pw_valid && (pw_addr == s2_nb[k])) ? pw_data : rd[k];
    end
    ups      = 3'(nb_bit[0]) + 3'(nb_bit[1]) + 3'(nb_bit[2]) + 3'(nb_bit[3]);
    upd_spin = (prob[ups] > s2_draw);
    spin_new = s2_ctrl.upd ? upd_spin : s2_ctrl.spin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_ctrl <= q_ctrl;
      s2_addr <= q_addr;
      s2_nb   <= q_nb;
      s2_draw <= q_draw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pw_valid <= 1'b0;
    end else if (s2_adv && s2_ctrl.wr_en) begin
      pw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_ctrl.wr_en) begin
      pw_addr <= s2_addr;
      pw_data <= spin_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      site_row   <= s2_ctrl.row;
      site_col   <= s2_ctrl.col;
      new_spin   <= spin_new;
      sweep_done <= s2_ctrl.done;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ising_heat_bath_sweep_unit.sv
// Channel  Handshake                    Payload
// item     item_valid / item_stall      kind, row, col, spin_value, random_draw
// result   result_valid / result_stall  site_row, site_col, new_spin, sweep_done
// config   cfg_valid / cfg_ready        cfg_index, cfg_data
//
// Sustains one item per cycle while item_stall is low; after its item is taken,
// a result passes the queue, the spin read and the result register.
// The spin memory sets that rate: two copies, each with one write and two
// read ports, give the four neighbour reads and the spin write every cycle.
// After rst all 2^(clog2(ROWS)+clog2(COLS)) spins (4096 at 64 x 64) are
// filled with +1, one per cycle; item_stall is high meanwhile.
// cfg_ready is always high.
// Once the fill is over, item_stall rises only when the four-entry queue
// between the site sequencer and the update pipeline is full.
`default_nettype none

module ising_heat_bath_sweep_unit #(
  parameter int ROWS = ihb_pkg::DEF_ROWS,
  parameter int COLS = ihb_pkg::DEF_COLS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            kind,
  input  logic [ihb_pkg::COORD_W-1:0]     row,
  input  logic [ihb_pkg::COORD_W-1:0]     col,
  input  logic                            spin_value,
  input  logic [ihb_pkg::FRAC_W-1:0]      random_draw,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [ihb_pkg::COORD_W-1:0]     site_row,
  output logic [ihb_pkg::COORD_W-1:0]     site_col,
  output logic                            new_spin,
  output logic                            sweep_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ihb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ihb_pkg::FRAC_W-1:0]      cfg_data
);

  localparam int AW = $clog2(ROWS) + $clog2(COLS);
  localparam int QW = $bits(ihb_pkg::item_ctrl_t) + (ihb_pkg::NUM_NB + 1) * AW
                      + ihb_pkg::FRAC_W;

  ihb_pkg::prob_tab_t            prob;
  logic [ihb_pkg::MODE_W-1:0]    mode;

  logic                                clear_busy;
  logic                                push;
  ihb_pkg::item_ctrl_t                 e_ctrl;
  logic [AW-1:0]                       e_addr;
  logic [ihb_pkg::NUM_NB-1:0][AW-1:0]  e_nb;
  logic [ihb_pkg::FRAC_W-1:0]          e_draw;

  logic                                q_full;
  logic                                q_valid;
  logic                                q_pop;
  logic [QW-1:0]                       q_rdata;
  ihb_pkg::item_ctrl_t                 q_ctrl;
  logic [AW-1:0]                       q_addr;
  logic [ihb_pkg::NUM_NB-1:0][AW-1:0]  q_nb;
  logic [ihb_pkg::FRAC_W-1:0]          q_draw;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prob <= {ihb_pkg::NUM_PROBS{ihb_pkg::PROB_RESET}};
      mode <= ihb_pkg::MODE_NEAREST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ihb_pkg::REG_PROB_M4, ihb_pkg::REG_PROB_M2, ihb_pkg::REG_PROB_ZERO,
        ihb_pkg::REG_PROB_P2, ihb_pkg::REG_PROB_P4: begin
          prob[cfg_index] <= cfg_data;
        end
        ihb_pkg::REG_SWEEP_MODE: begin
          mode <= cfg_data[ihb_pkg::MODE_W-1:0];
        end
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  ihb_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .kind        (kind),
    .row         (row),
    .col         (col),
    .spin_value  (spin_value),
    .random_draw (random_draw),
    .mode        (mode),
    .q_full      (q_full),
    .clear_busy  (clear_busy),
    .push        (push),
    .e_ctrl      (e_ctrl),
    .e_addr      (e_addr),
    .e_nb        (e_nb),
    .e_draw      (e_draw)
  );

  ihb_queue #(.W(QW), .DEPTH(ihb_pkg::QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({e_ctrl, e_addr, e_nb, e_draw}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid),
    .full  (q_full)
  );

  assign {q_ctrl, q_addr, q_nb, q_draw} = q_rdata;

  ihb_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .prob         (prob),
    .q_valid      (q_valid),
    .q_ctrl       (q_ctrl),
    .q_addr       (q_addr),
    .q_nb         (q_nb),
    .q_draw       (q_draw),
    .q_pop        (q_pop),
    .clear_busy   (clear_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .site_row     (site_row),
    .site_col     (site_col),
    .new_spin     (new_spin),
    .sweep_done   (sweep_done)
  );

endmodule

`default_nettype wire

FILE: rtl/ihb_checker.sv
`default_nettype none
`include "assert_macros.svh"

module ihb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_stall,
  input logic                        result_valid,
  input logic                        result_stall,
  input logic [ihb_pkg::COORD_W-1:0] site_row,
  input logic [ihb_pkg::COORD_W-1:0] site_col,
  input logic                        new_spin,
  input logic                        sweep_done
);

  localparam int PND_W   = $clog2(ihb_pkg::QUEUE_DEPTH + 3);
  localparam int PND_MAX = ihb_pkg::QUEUE_DEPTH + 2;

  logic             take_in;
  logic             take_out;
  logic [PND_W-1:0] pending;

  assign take_in  = item_valid && !item_stall;
  assign take_out = result_valid && !result_stall;

  // Items taken whose results are not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (take_in && !take_out) begin
      pending <= pending + PND_W'(1);
    end else if (!take_in && take_out) begin
      pending <= pending - PND_W'(1);
    end
  end

  `IHB_ASSERT_ALWAYS(a_clear_after_reset, rst |=> item_stall, "items taken during spin fill")
  `IHB_ASSERT(a_no_orphan_result, result_valid |-> (pending != '0), "result without a taken item")
  `IHB_ASSERT(a_pending_bound, pending <= PND_W'(PND_MAX), "more items in flight than stages")
  `IHB_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(site_row) && $stable(site_col) && $stable(new_spin) && $stable(sweep_done), "stalled result changed")

endmodule

bind ising_heat_bath_sweep_unit ihb_checker u_ihb_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .site_row     (site_row),
  .site_col     (site_col),
  .new_spin     (new_spin),
  .sweep_done   (sweep_done)
);

`default_nettype wire
